@@ rtl/rv32_pkg.sv @@
// shared types and constants for the rv32im execute unit
package rv32_pkg;

    typedef enum logic [6:0] {
        OP_REG    = 7'h33,
        OP_IMM    = 7'h13,
        OP_LOAD   = 7'h03,
        OP_STORE  = 7'h23,
        OP_BRANCH = 7'h63,
        OP_JAL    = 7'h6f,
        OP_JALR   = 7'h67,
        OP_LUI    = 7'h37,
        OP_AUIPC  = 7'h17,
        OP_FENCE  = 7'h0f,
        OP_SYSTEM = 7'h73
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EBREAK  = 2'd1,
        ST_ECALL   = 2'd2,
        ST_ILLEGAL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } mem_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVFIX,
        S_DONE
    } state_t;

    localparam logic [31:0] INSTR_EBREAK  = 32'h0010_0073;
    localparam logic [31:0] INSTR_ECALL   = 32'h0000_0073;
    localparam logic [31:0] INSTR_WFI     = 32'h1050_0073;
    localparam logic [31:0] INSTR_FENCE_I = 32'h0000_100f;

endpackage

@@ rtl/rv32im_execute_unit.sv @@
// rv32im execute unit: decode, register file memory, alu, multiply and iterative divide
//
//  channel | signals                                        | accepted when
//  --------+------------------------------------------------+----------------------
//  in      | cmd instr pc load_data                         | in_valid & in_ready
//  out     | next_pc mem_op mem_addr mem_bytes store_data   | out_valid & out_ready
//          | wb_enable wb_reg wb_value status               |
//
// one request at a time; an execute request passes the register file read, execute and
// result states, and the next request is accepted after its result is taken; a multiply
// adds one 33x33 product stage, a divide or remainder 32 steps of the one-bit restoring
// divider plus sign fix; a load return takes the same path as an execute
// reset clears the control state; the register file is zeroed by written-bit flags
// a stalled result holds in the output registers until taken
module rv32im_execute_unit
    import rv32_pkg::*;
#(
    parameter int REG_COUNT = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] instr,
    input  logic [31:0] pc,
    input  logic [31:0] load_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_pc,
    output logic [1:0]  mem_op,
    output logic [31:0] mem_addr,
    output logic [2:0]  mem_bytes,
    output logic [31:0] store_data,
    output logic        wb_enable,
    output logic [4:0]  wb_reg,
    output logic [31:0] wb_value,
    output logic [1:0]  status
);

    state_t state_reg, state_next;

    // captured request
    logic        cmd_reg;
    logic [31:0] instr_reg, pc_reg, ld_reg;

    // register file memory and written flags
    logic [31:0] rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_written_reg;
    logic [31:0] rs1_raw_reg, rs2_raw_reg;
    logic        rs1_ok_reg, rs2_ok_reg;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;

    // pending load slot
    logic [4:0]  pl_reg_reg;
    logic [1:0]  pl_size_reg;
    logic        pl_signed_reg, pl_valid_reg;

    // result registers
    logic [31:0] next_pc_reg, mem_addr_reg, store_data_reg, wb_value_reg;
    logic [1:0]  mem_op_reg, status_reg;
    logic [2:0]  mem_bytes_reg;
    logic        wb_enable_reg;
    logic [4:0]  wb_reg_reg;

    // multiply and divide
    logic [65:0] prod_reg;
    logic [31:0] quo_reg, rem_reg, dvs_reg, div_a_reg;
    logic [5:0]  cnt_reg;
    logic        neg_q_reg, neg_r_reg;

    // decode fields
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, pc4;
    assign op  = instr_reg[6:0];
    assign rd  = instr_reg[11:7];
    assign f3  = instr_reg[14:12];
    assign rs1 = instr_reg[19:15];
    assign rs2 = instr_reg[24:20];
    assign f7  = instr_reg[31:25];
    assign a   = rs1_ok_reg ? rs1_raw_reg : 32'd0;
    assign b   = rs2_ok_reg ? rs2_raw_reg : 32'd0;
    assign imm_i = {{20{instr_reg[31]}}, instr_reg[31:20]};
    assign imm_s = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
    assign imm_b = {{20{instr_reg[31]}}, instr_reg[7], instr_reg[30:25],
                    instr_reg[11:8], 1'b0};
    assign imm_j = {{12{instr_reg[31]}}, instr_reg[19:12], instr_reg[20],
                    instr_reg[30:21], 1'b0};
    assign pc4 = pc_reg + 32'd4;

    // handshake
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    // register index check
    function automatic logic idx_ok(input logic [4:0] i);
        return (i != 5'd0) && (32'(i) < REG_COUNT);
    endfunction

    // execute decode
    logic        is_md, is_div;
    logic [31:0] alu_b, alu_y;
    logic        alt, take;
    logic [31:0] ex_npc, ex_addr, ex_sdata, ex_wval;
    logic [1:0]  ex_mop, ex_st;
    logic [2:0]  ex_bytes;
    logic        ex_wb, ex_load;

    always_comb
    begin
        is_md  = (op == OP_REG) && (f7 == 7'd1);
        is_div = is_md && f3[2];
    end

    // alu
    always_comb
    begin
        alu_b = (op == OP_REG) ? b : imm_i;
        alt   = (op == OP_REG) ? (f7 == 7'h20) : (f3 == 3'd5 && f7 == 7'h20);
        case (f3)
            3'd0: alu_y = alt ? a - alu_b : a + alu_b;
            3'd1: alu_y = a << alu_b[4:0];
            3'd2: alu_y = {31'd0, $signed(a) < $signed(alu_b)};
            3'd3: alu_y = {31'd0, a < alu_b};
            3'd4: alu_y = a ^ alu_b;
            3'd5: alu_y = alt ? 32'($signed(a) >>> alu_b[4:0]) : a >> alu_b[4:0];
            3'd6: alu_y = a | alu_b;
            default: alu_y = a & alu_b;
        endcase
    end

    // instruction decode and result selection
    always_comb
    begin
        ex_npc = pc4; ex_addr = '0; ex_sdata = '0; ex_wval = '0;
        ex_mop = MEM_NONE; ex_st = ST_OK; ex_bytes = '0; ex_wb = 1'b0;
        ex_load = 1'b0; take = 1'b0;
        unique case (op)
            OP_REG:
            begin
                if (f7 == 7'd0 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))
                begin
                    ex_wb = 1'b1; ex_wval = alu_y;
                end
                else if (f7 == 7'd1) ex_wb = 1'b1;
                else ex_st = ST_ILLEGAL;
            end
            OP_IMM:
            begin
                if ((f3 == 3'd1 && f7 != 7'd0) ||
                    (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20))
                    ex_st = ST_ILLEGAL;
                else
                begin
                    ex_wb = 1'b1; ex_wval = alu_y;
                end
            end
            OP_LOAD:
            begin
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) ex_st = ST_ILLEGAL;
                else
                begin
                    ex_mop = MEM_LOAD; ex_addr = a + imm_i;
                    ex_bytes = 3'(3'd1 << f3[1:0]); ex_load = 1'b1;
                end
            end
            OP_STORE:
            begin
                if (f3 > 3'd2) ex_st = ST_ILLEGAL;
                else
                begin
                    ex_mop = MEM_STORE; ex_addr = a + imm_s;
                    ex_bytes = 3'(3'd1 << f3[1:0]); ex_sdata = b;
                end
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: take = (a == b);
                    3'd1: take = (a != b);
                    3'd4: take = $signed(a) < $signed(b);
                    3'd5: take = !($signed(a) < $signed(b));
                    3'd6: take = a < b;
                    3'd7: take = a >= b;
                    default: ex_st = ST_ILLEGAL;
                endcase
                if (take) ex_npc = pc_reg + imm_b;
            end
            OP_JAL:
            begin
                ex_npc = pc_reg + imm_j; ex_wb = 1'b1; ex_wval = pc4;
            end
            OP_JALR:
            begin
                if (f3 != 3'd0) ex_st = ST_ILLEGAL;
                else
                begin
                    ex_npc = (a + imm_i) & ~32'd1; ex_wb = 1'b1; ex_wval = pc4;
                end
            end
            OP_LUI:
            begin
                ex_wb = 1'b1; ex_wval = {instr_reg[31:12], 12'd0};
            end
            OP_AUIPC:
            begin
                ex_wb = 1'b1; ex_wval = pc_reg + {instr_reg[31:12], 12'd0};
            end
            OP_FENCE:
            begin
                if (f3 != 3'd0 && instr_reg != INSTR_FENCE_I) ex_st = ST_ILLEGAL;
            end
            OP_SYSTEM:
            begin
                if (instr_reg == INSTR_EBREAK) ex_st = ST_EBREAK;
                else if (instr_reg == INSTR_ECALL) ex_st = ST_ECALL;
                else if (instr_reg != INSTR_WFI) ex_st = ST_ILLEGAL;
            end
            default: ex_st = ST_ILLEGAL;
        endcase
    end

    // load return extension
    logic [31:0] ld_val;
    always_comb
    begin
        case (pl_size_reg)
            2'd0: ld_val = pl_signed_reg ? {{24{ld_reg[7]}}, ld_reg[7:0]}
                                         : {24'd0, ld_reg[7:0]};
            2'd1: ld_val = pl_signed_reg ? {{16{ld_reg[15]}}, ld_reg[15:0]}
                                         : {16'd0, ld_reg[15:0]};
            default: ld_val = ld_reg;
        endcase
    end

    // multiply operands and divide step
    logic [32:0] mul_a, mul_b;
    logic [31:0] mag_a, mag_b, mul_res, div_res;
    logic [33:0] trial;
    logic [32:0] rem_shift;
    logic        div_signed, div_zero, div_ovf;
    always_comb
    begin
        mul_a = (f3 == 3'd1 || f3 == 3'd2) ? {a[31], a} : {1'b0, a};
        mul_b = (f3 == 3'd1) ? {b[31], b} : {1'b0, b};
        div_signed = !f3[0];
        mag_a = (div_signed && a[31]) ? 32'd0 - a : a;
        mag_b = (div_signed && b[31]) ? 32'd0 - b : b;
        mul_res = (f3 == 3'd0) ? prod_reg[31:0] : prod_reg[63:32];
        rem_shift = {rem_reg, div_a_reg[31]};
        trial = {1'b0, rem_shift} - {2'b0, dvs_reg};
        div_zero = (b == 32'd0);
        div_ovf  = div_signed && a == 32'h8000_0000 && b == 32'hffff_ffff;
        if (div_zero) div_res = f3[1] ? a : 32'hffff_ffff;
        else if (div_ovf) div_res = f3[1] ? 32'd0 : a;
        else if (f3[1]) div_res = neg_r_reg ? 32'd0 - rem_reg : rem_reg;
        else div_res = neg_q_reg ? 32'd0 - quo_reg : quo_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_READ;
            S_READ:   state_next = S_EXEC;
            S_EXEC:
            begin
                if (!cmd_reg && is_div) state_next = S_DIV;
                else if (!cmd_reg && is_md) state_next = S_MUL;
                else state_next = S_DONE;
            end
            S_MUL:    state_next = S_DONE;
            S_DIV:    if (cnt_reg == 6'd31) state_next = S_DIVFIX;
            S_DIVFIX: state_next = S_DONE;
            S_DONE:   if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // write back selection
    logic        res_we;
    logic [4:0]  res_dst;
    logic [31:0] res_val;
    always_comb
    begin
        res_we = 1'b0; res_dst = rd; res_val = ex_wval;
        unique case (state_reg)
            S_EXEC:
            begin
                if (cmd_reg)
                begin
                    res_we = pl_valid_reg; res_dst = pl_reg_reg; res_val = ld_val;
                end
                else res_we = ex_wb && !is_md;
            end
            S_MUL:    begin res_we = 1'b1; res_val = mul_res; end
            S_DIVFIX: begin res_we = 1'b1; res_val = div_res; end
            default:  res_we = 1'b0;
        endcase
        rf_we    = res_we && idx_ok(res_dst);
        rf_waddr = res_dst;
        rf_wdata = res_val;
    end

    // register file memory
    always_ff @(posedge clk)
    begin
        if (rf_we) rf_mem[rf_waddr[$clog2(REG_COUNT)-1:0]] <= rf_wdata;
        rs1_raw_reg <= rf_mem[instr_reg[15+:$clog2(REG_COUNT)]];
        rs2_raw_reg <= rf_mem[instr_reg[20+:$clog2(REG_COUNT)]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rf_written_reg <= '0;
            pl_valid_reg   <= 1'b0;
            pl_reg_reg     <= '0;
            pl_size_reg    <= '0;
            pl_signed_reg  <= 1'b0;
            rs1_ok_reg     <= 1'b0;
            rs2_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rf_we) rf_written_reg[rf_waddr[$clog2(REG_COUNT)-1:0]] <= 1'b1;
            if (state_reg == S_READ)
            begin
                rs1_ok_reg <= idx_ok(rs1) && rf_written_reg[rs1[$clog2(REG_COUNT)-1:0]];
                rs2_ok_reg <= idx_ok(rs2) && rf_written_reg[rs2[$clog2(REG_COUNT)-1:0]];
            end
            if (state_reg == S_EXEC)
            begin
                if (cmd_reg) pl_valid_reg <= 1'b0;
                else if (ex_load)
                begin
                    pl_valid_reg  <= 1'b1;
                    pl_reg_reg    <= rd;
                    pl_size_reg   <= f3[1:0];
                    pl_signed_reg <= !f3[2];
                end
            end
        end
    end

    // request capture, datapath and result registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd; instr_reg <= instr; pc_reg <= pc; ld_reg <= load_data;
        end
        if (state_reg == S_EXEC)
        begin
            prod_reg  <= 66'($signed(mul_a) * $signed(mul_b));
            dvs_reg   <= mag_b;
            div_a_reg <= mag_a;
            rem_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            neg_q_reg <= div_signed && (a[31] ^ b[31]);
            neg_r_reg <= div_signed && a[31];
            if (cmd_reg)
            begin
                next_pc_reg <= '0; mem_op_reg <= MEM_NONE; mem_addr_reg <= '0;
                mem_bytes_reg <= '0; store_data_reg <= '0; status_reg <= ST_OK;
            end
            else
            begin
                next_pc_reg <= ex_npc; mem_op_reg <= ex_mop; mem_addr_reg <= ex_addr;
                mem_bytes_reg <= ex_bytes; store_data_reg <= ex_sdata;
                status_reg <= ex_st;
            end
        end
        if (state_reg == S_DIV)
        begin
            div_a_reg <= {div_a_reg[30:0], 1'b0};
            cnt_reg   <= cnt_reg + 6'd1;
            if (!trial[33])
            begin
                rem_reg <= trial[31:0]; quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[31:0]; quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (state_reg == S_EXEC || state_reg == S_MUL || state_reg == S_DIVFIX)
        begin
            wb_enable_reg <= rf_we;
            wb_reg_reg    <= rf_we ? rf_waddr : 5'd0;
            wb_value_reg  <= rf_we ? rf_wdata : 32'd0;
        end
    end

    // outputs
    assign next_pc    = next_pc_reg;
    assign mem_op     = mem_op_reg;
    assign mem_addr   = mem_addr_reg;
    assign mem_bytes  = mem_bytes_reg;
    assign store_data = store_data_reg;
    assign wb_enable  = wb_enable_reg;
    assign wb_reg     = wb_reg_reg;
    assign wb_value   = wb_value_reg;
    assign status     = status_reg;

endmodule

@@ rtl/rv32_checker.sv @@
// port checker for the rv32im execute unit, bound to the top level
module rv32_checker
    import rv32_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        wb_enable,
    input logic [4:0]  wb_reg,
    input logic [31:0] wb_value,
    input logic [1:0]  mem_op,
    input logic [2:0]  mem_bytes,
    input logic [31:0] next_pc
);

    // no new request while a result is shown
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while result pending");

    // a result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(wb_value))
        else $error("result changed while stalled");

    // x0 is never written
    a_x0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wb_enable |-> wb_reg != 5'd0)
        else $error("write to x0 reported");

    // a result without a memory request reports a size of zero
    a_mem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mem_op == MEM_NONE |-> mem_bytes == 3'd0)
        else $error("size without memory request");

    // accepting a request never produces a result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

endmodule

bind rv32im_execute_unit rv32_checker u_rv32_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .wb_enable(wb_enable),
    .wb_reg(wb_reg), .wb_value(wb_value), .mem_op(mem_op),
    .mem_bytes(mem_bytes), .next_pc(next_pc)
);

@@ tb/tb.sv @@
// self-checking testbench for the rv32im execute unit
module tb;
    import rv32_pkg::*;

    // result fields as the block reports them
    typedef struct packed {
        logic [31:0] npc;
        logic [1:0]  mop;
        logic [31:0] maddr;
        logic [2:0]  mbytes;
        logic [31:0] sdata;
        logic        wben;
        logic [4:0]  wbreg;
        logic [31:0] wbval;
        logic [1:0]  st;
    } exec_result_t;

    // one input request plus optional directly typed expectation
    typedef struct {
        logic        c;
        logic [31:0] ins;
        logic [31:0] addr;
        logic [31:0] ld;
        logic        has_exp;
        exec_result_t exp_res;
    } request_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [31:0] instr;
    logic [31:0] pc;
    logic [31:0] load_data;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [2:0]  mem_bytes;
    logic [31:0] store_data;
    logic        wb_enable;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
    logic [1:0]  status;

    rv32im_execute_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .instr(instr), .pc(pc), .load_data(load_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .next_pc(next_pc), .mem_op(mem_op), .mem_addr(mem_addr),
        .mem_bytes(mem_bytes), .store_data(store_data),
        .wb_enable(wb_enable), .wb_reg(wb_reg), .wb_value(wb_value),
        .status(status)
    );

    // shadow architectural state
    logic [31:0] shadow_regs [32];
    logic [4:0]  ld_dest;
    logic [1:0]  ld_size;
    logic        ld_signed;
    logic        ld_pending;

    exec_result_t expected_results [$];
    request_t     directed_table [$];

    int mismatches = 0;
    int results_seen = 0;
    int requests_sent = 0;
    int loads_returned = 0;
    int divides_sent = 0;
    int idle_cycles = 0;
    bit timed_out = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [31:0] read_reg(logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : shadow_regs[idx];
    endfunction

    function automatic logic [31:0] sign_ext(logic [31:0] v, int bits);
        logic [31:0] m;
        m = (bits >= 32) ? 32'hffff_ffff : ((32'd1 << bits) - 32'd1);
        v = v & m;
        if (bits < 32 && v[bits-1])
            v = v | ~m;
        return v;
    endfunction

    function automatic logic [31:0] int_alu(logic [2:0] f3, logic [31:0] a, logic [31:0] b,
                                            logic alt);
        case (f3)
            3'd0: return alt ? a - b : a + b;
            3'd1: return a << b[4:0];
            3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            3'd3: return (a < b) ? 32'd1 : 32'd0;
            3'd4: return a ^ b;
            3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            3'd6: return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic logic [31:0] mul_div(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [63:0] p;
        logic [31:0] ma;
        logic [31:0] mb;
        sa = {{32{a[31]}}, a};
        sb = {{32{b[31]}}, b};
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (f3)
            3'd0: return a * b;
            3'd1: begin p = sa * sb; return p[63:32]; end
            3'd2: begin p = sa * {32'd0, b}; return p[63:32]; end
            3'd3: begin p = {32'd0, a} * {32'd0, b}; return p[63:32]; end
            3'd4:
            begin
                if (b == 0) return 32'hffff_ffff;
                if (a == 32'h8000_0000 && b == 32'hffff_ffff) return a;
                return (a[31] ^ b[31]) ? -(ma / mb) : ma / mb;
            end
            3'd5: return (b == 0) ? 32'hffff_ffff : a / b;
            3'd6:
            begin
                if (b == 0) return a;
                if (a == 32'h8000_0000 && b == 32'hffff_ffff) return 32'd0;
                return a[31] ? -(ma % mb) : ma % mb;
            end
            default: return (b == 0) ? a : a % b;
        endcase
    endfunction

    // predicts one result and advances the shadow state
    function automatic exec_result_t execute_predict(logic c, logic [31:0] ins,
                                                     logic [31:0] addr, logic [31:0] ld);
        exec_result_t r;
        logic wb;
        logic [4:0] dst;
        logic [31:0] val;
        logic [6:0] op;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic take;
        r = '0;
        wb = 0;
        dst = 0;
        val = 0;
        if (c) begin
            if (ld_pending) begin
                case (ld_size)
                    2'd0: val = ld_signed ? sign_ext(ld, 8) : {24'd0, ld[7:0]};
                    2'd1: val = ld_signed ? sign_ext(ld, 16) : {16'd0, ld[15:0]};
                    default: val = ld;
                endcase
                wb = 1;
                dst = ld_dest;
                ld_pending = 0;
            end
        end else begin
            op = ins[6:0];
            f3 = ins[14:12];
            f7 = ins[31:25];
            a = read_reg(ins[19:15]);
            b = read_reg(ins[24:20]);
            imm_i = sign_ext({20'd0, ins[31:20]}, 12);
            imm_s = sign_ext({20'd0, ins[31:25], ins[11:7]}, 12);
            imm_b = sign_ext({19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
            imm_j = sign_ext({11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
            r.npc = addr + 32'd4;
            r.st = ST_OK;
            case (op)
                OP_REG:
                    if (f7 == 7'h00) begin wb = 1; val = int_alu(f3, a, b, 0); end
                    else if (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))
                    begin wb = 1; val = int_alu(f3, a, b, 1); end
                    else if (f7 == 7'h01) begin wb = 1; val = mul_div(f3, a, b); end
                    else r.st = ST_ILLEGAL;
                OP_IMM:
                    if (f3 == 3'd1) begin
                        if (f7 == 7'h00) begin wb = 1; val = int_alu(f3, a, imm_i, 0); end
                        else r.st = ST_ILLEGAL;
                    end else if (f3 == 3'd5) begin
                        if (f7 == 7'h00) begin wb = 1; val = int_alu(f3, a, imm_i, 0); end
                        else if (f7 == 7'h20) begin wb = 1; val = int_alu(f3, a, imm_i, 1); end
                        else r.st = ST_ILLEGAL;
                    end else begin
                        wb = 1;
                        val = int_alu(f3, a, imm_i, 0);
                    end
                OP_LOAD:
                    if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) r.st = ST_ILLEGAL;
                    else begin
                        r.mop = MEM_LOAD;
                        r.maddr = a + imm_i;
                        r.mbytes = 3'd1 << f3[1:0];
                        ld_dest = ins[11:7];
                        ld_size = f3[1:0];
                        ld_signed = !f3[2];
                        ld_pending = 1;
                    end
                OP_STORE:
                    if (f3 > 3'd2) r.st = ST_ILLEGAL;
                    else begin
                        r.mop = MEM_STORE;
                        r.maddr = a + imm_s;
                        r.mbytes = 3'd1 << f3[1:0];
                        r.sdata = b;
                    end
                OP_BRANCH:
                begin
                    take = 0;
                    case (f3)
                        3'd0: take = (a == b);
                        3'd1: take = (a != b);
                        3'd4: take = $signed(a) < $signed(b);
                        3'd5: take = $signed(a) >= $signed(b);
                        3'd6: take = a < b;
                        3'd7: take = a >= b;
                        default: r.st = ST_ILLEGAL;
                    endcase
                    if (take) r.npc = addr + imm_b;
                end
                OP_JAL:
                begin
                    r.npc = addr + imm_j;
                    wb = 1;
                    val = addr + 32'd4;
                end
                OP_JALR:
                    if (f3 != 3'd0) r.st = ST_ILLEGAL;
                    else begin
                        r.npc = (a + imm_i) & ~32'd1;
                        wb = 1;
                        val = addr + 32'd4;
                    end
                OP_LUI: begin wb = 1; val = {ins[31:12], 12'd0}; end
                OP_AUIPC: begin wb = 1; val = addr + {ins[31:12], 12'd0}; end
                OP_FENCE:
                    if (f3 != 3'd0 && ins != INSTR_FENCE_I) r.st = ST_ILLEGAL;
                OP_SYSTEM:
                    if (ins == INSTR_EBREAK) r.st = ST_EBREAK;
                    else if (ins == INSTR_ECALL) r.st = ST_ECALL;
                    else if (ins != INSTR_WFI) r.st = ST_ILLEGAL;
                default: r.st = ST_ILLEGAL;
            endcase
            dst = ins[11:7];
        end
        if (wb && dst != 0) begin
            shadow_regs[dst] = val;
            r.wben = 1;
            r.wbreg = dst;
            r.wbval = val;
        end
        return r;
    endfunction

    // instruction encoders
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, 7'(OP_REG)};
    endfunction

    function automatic logic [31:0] enc_i(logic [6:0] op, logic [11:0] imm, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], 7'(OP_STORE)};
    endfunction

    function automatic exec_result_t fixed_result(logic [31:0] npc, logic wben, logic [4:0] rd,
                                                  logic [31:0] v, logic [1:0] st);
        exec_result_t r;
        r = '0;
        r.npc = npc;
        r.wben = wben;
        r.wbreg = rd;
        r.wbval = v;
        r.st = st;
        return r;
    endfunction

    function automatic request_t make_req(logic c, logic [31:0] ins, logic [31:0] addr,
                                          logic [31:0] ld);
        request_t q;
        q.c = c;
        q.ins = ins;
        q.addr = addr;
        q.ld = ld;
        q.has_exp = 0;
        q.exp_res = '0;
        return q;
    endfunction

    function automatic request_t make_fixed(logic c, logic [31:0] ins, logic [31:0] addr,
                                            logic [31:0] ld, exec_result_t e);
        request_t q;
        q = make_req(c, ins, addr, ld);
        q.has_exp = 1;
        q.exp_res = e;
        return q;
    endfunction

    // random instruction, mostly well-formed with some noise
    function automatic logic [31:0] random_instr();
        int sel;
        logic [2:0] f3;
        logic [4:0] rd;
        logic [4:0] rs1;
        logic [4:0] rs2;
        sel = $urandom_range(0, 99);
        f3 = 3'($urandom);
        rd = 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        if ($urandom_range(0, 3) == 0) rs1 = 5'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) rs2 = 5'($urandom_range(0, 7));
        if (sel < 18) return enc_r(($urandom_range(0, 1) != 0) ? 7'h00 : 7'h20, rs2, rs1, f3, rd);
        if (sel < 34) return enc_r(7'h01, rs2, rs1, f3, rd);
        if (sel < 50) begin
            if (f3 == 3'd1 || f3 == 3'd5)
                return enc_i(OP_IMM, {($urandom_range(0, 1) != 0) ? 7'h20 : 7'h00, rs2},
                             rs1, f3, rd);
            return enc_i(OP_IMM, 12'($urandom), rs1, f3, rd);
        end
        if (sel < 60) return enc_i(OP_LOAD, 12'($urandom), rs1, f3, rd);
        if (sel < 68) return enc_s(12'($urandom), rs2, rs1, f3);
        if (sel < 76) return {$urandom_range(0, 1) != 0 ? 1'b1 : 1'b0, 6'($urandom), rs2, rs1,
                              f3, 5'($urandom), 7'(OP_BRANCH)};
        if (sel < 79) return {20'($urandom), rd, 7'(OP_JAL)};
        if (sel < 82) return enc_i(OP_JALR, 12'($urandom), rs1, f3, rd);
        if (sel < 86) return {20'($urandom), rd, 7'(OP_LUI)};
        if (sel < 90) return {20'($urandom), rd, 7'(OP_AUIPC)};
        if (sel < 92) return {25'($urandom), 7'(OP_FENCE)};
        if (sel < 95) begin
            case ($urandom_range(0, 3))
                0: return INSTR_EBREAK;
                1: return INSTR_ECALL;
                2: return INSTR_WFI;
                default: return {25'($urandom), 7'(OP_SYSTEM)};
            endcase
        end
        return $urandom;
    endfunction

    // drive one request and wait for its acceptance
    task automatic send_request(request_t q);
        exec_result_t e;
        logic had_pending;
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct)
            @(posedge clk);
        cmd <= q.c;
        instr <= q.ins;
        pc <= q.addr;
        load_data <= q.ld;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        had_pending = ld_pending;
        e = execute_predict(q.c, q.ins, q.addr, q.ld);
        if (q.has_exp && e !== q.exp_res)
            $display("note: typed expectation differs from prediction for %h", q.ins);
        expected_results.push_back(q.has_exp ? q.exp_res : e);
        requests_sent++;
        if (q.c && had_pending) loads_returned++;
        if (!q.c && q.ins[6:0] == OP_REG && q.ins[31:25] == 7'h01 && q.ins[14]) divides_sent++;
        // drop valid between requests; the unit is busy after an accept anyway
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // result checker and receiver stalls
    always @(posedge clk) begin
        exec_result_t got;
        exec_result_t exp_r;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = '{next_pc, mem_op, mem_addr, mem_bytes, store_data,
                        wb_enable, wb_reg, wb_value, status};
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp npc=%h mop=%0d addr=%h by=%0d sd=%h wb=%0d/%0d/%h st=%0d got npc=%h mop=%0d addr=%h by=%0d sd=%h wb=%0d/%0d/%h st=%0d",
                                exp_r.npc, exp_r.mop, exp_r.maddr, exp_r.mbytes, exp_r.sdata,
                                exp_r.wben, exp_r.wbreg, exp_r.wbval, exp_r.st,
                                got.npc, got.mop, got.maddr, got.mbytes, got.sdata,
                                got.wben, got.wbreg, got.wbval, got.st);
                    end
                end
            end
            out_ready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        request_t q;
        int phase;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b1;
        cmd = 1'b0;
        instr = '0;
        pc = '0;
        load_data = '0;
        for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
        ld_dest = 0;
        ld_size = 0;
        ld_signed = 0;
        ld_pending = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        directed_table.push_back(make_fixed(1, 32'h0, 32'h0, 32'hffff_ffff, '0));
        directed_table.push_back(make_fixed(0, {20'hfffff, 5'd1, 7'(OP_LUI)}, 32'h0, 0,
                                 fixed_result(32'd4, 1, 5'd1, 32'hffff_f000, ST_OK)));
        directed_table.push_back(make_req(0, enc_i(OP_IMM, 12'hfff, 5'd1, 3'd0, 5'd2),
                                          32'hffff_fffc, 0));
        directed_table.push_back(make_req(0, {20'h80000, 5'd3, 7'(OP_LUI)}, 32'h100, 0));
        directed_table.push_back(make_req(0, enc_r(7'h01, 5'd2, 5'd3, 3'd4, 5'd4), 0, 0));
        directed_table.push_back(make_req(0, enc_r(7'h01, 5'd2, 5'd3, 3'd6, 5'd5), 0, 0));
        directed_table.push_back(make_req(0, enc_r(7'h01, 5'd0, 5'd3, 3'd4, 5'd6), 0, 0));
        directed_table.push_back(make_req(0, enc_r(7'h01, 5'd0, 5'd3, 3'd7, 5'd7), 0, 0));
        directed_table.push_back(make_req(0, enc_r(7'h01, 5'd2, 5'd3, 3'd1, 5'd8), 0, 0));
        directed_table.push_back(make_req(0, enc_i(OP_IMM, {7'h20, 5'd31}, 5'd3, 3'd5, 5'd9),
                                          0, 0));
        directed_table.push_back(make_fixed(0, enc_i(OP_IMM, {7'h10, 5'd1}, 5'd3, 3'd1, 5'd9),
                                 32'h40, 0, fixed_result(32'h44, 0, 0, 0, ST_ILLEGAL)));
        directed_table.push_back(make_req(0, enc_r(7'h00, 5'd2, 5'd3, 3'd5, 5'd0), 0, 0));
        directed_table.push_back(make_req(0, enc_i(OP_JALR, 12'h7ff, 5'd2, 3'd0, 5'd10),
                                          32'h200, 0));
        directed_table.push_back(make_req(0, {1'b1, 10'h3ff, 1'b1, 8'hff, 5'd11, 7'(OP_JAL)},
                                          32'h1000, 0));
        directed_table.push_back(make_req(0, {1'b1, 6'h3f, 5'd0, 5'd0, 3'd0, 4'hf, 1'b1,
                                          7'(OP_BRANCH)}, 32'h400, 0));
        directed_table.push_back(make_req(0, enc_i(OP_LOAD, 12'h800, 5'd1, 3'd0, 5'd12),
                                          0, 0));
        directed_table.push_back(make_req(1, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0080));
        directed_table.push_back(make_req(0, enc_i(OP_LOAD, 12'h7ff, 5'd3, 3'd5, 5'd0), 0, 0));
        directed_table.push_back(make_req(1, 0, 0, 32'hffff_8000));
        directed_table.push_back(make_req(0, enc_s(12'h800, 5'd1, 5'd3, 3'd2), 0, 0));
        directed_table.push_back(make_fixed(0, {20'($urandom), 5'd1, 7'(OP_AUIPC)} & 32'h0,
                                 32'h10, 0, fixed_result(32'h14, 0, 0, 0, ST_ILLEGAL)));
        directed_table.push_back(make_fixed(0, INSTR_EBREAK, 32'h20, 0,
                                 fixed_result(32'h24, 0, 0, 0, ST_EBREAK)));
        directed_table.push_back(make_fixed(0, INSTR_ECALL, 32'h20, 0,
                                 fixed_result(32'h24, 0, 0, 0, ST_ECALL)));
        directed_table.push_back(make_fixed(0, INSTR_WFI, 32'h20, 0,
                                 fixed_result(32'h24, 0, 0, 0, ST_OK)));
        directed_table.push_back(make_fixed(0, INSTR_FENCE_I, 32'h20, 0,
                                 fixed_result(32'h24, 0, 0, 0, ST_OK)));
        foreach (directed_table[i]) send_request(directed_table[i]);
        wait_drained();

        // random phases with varied idling
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 77; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 77; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (n = 0; n < 425; n++) begin
                if ($urandom_range(0, 7) == 0 || (ld_pending && $urandom_range(0, 2) == 0))
                    q = make_req(1, $urandom, $urandom, $urandom);
                else
                    q = make_req(0, random_instr(), $urandom, $urandom);
                send_request(q);
                if (n == 200) wait_drained();
            end
            wait_drained();
        end

        recv_stall_pct = 0;
        wait_drained();
        repeat (50) @(posedge clk);
        $display("sent %0d requests (%0d divide/remainder, %0d load returns), checked %0d results",
                 requests_sent, divides_sent, loads_returned, results_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
